@@ rtl/core/pdrm_pkg.sv @@
// Shared widths, codes and types for the debounced tachometer edge counter.
`timescale 1ns / 1ps

package pdrm_pkg;

  localparam int TIME_W            = 32;
  localparam int DEB_W             = 16;
  localparam int PPR_W             = 16;
  localparam int OUT_W             = 16;
  localparam int CFG_AW            = 3;
  localparam int CFG_DW            = 32;
  localparam int HISTORY_DEPTH_DEF = 16;
  localparam int MAX_INTERVALS     = 5;

  // interval count and sum of up to MAX_INTERVALS 32-bit intervals
  localparam int KW   = $clog2(MAX_INTERVALS + 1);
  localparam int SUMW = TIME_W + KW;
  localparam int DENW = SUMW + PPR_W;
  // numerator holds 600000 * MAX_INTERVALS and 10000 * HISTORY_DEPTH
  localparam int NUMW = 24;

  localparam logic [NUMW-1:0]  RATE_SCALE = NUMW'(10000);
  localparam logic [NUMW-1:0]  RPM_SCALE  = NUMW'(600000);
  localparam logic [OUT_W-1:0] SAT_MAX    = OUT_W'(65535);

  localparam logic [DEB_W-1:0]  DEBOUNCE_RST  = DEB_W'(5);
  localparam logic [TIME_W-1:0] WINDOW_RST    = TIME_W'(1000);
  localparam logic [PPR_W-1:0]  PPR_RST       = PPR_W'(1);
  localparam logic [TIME_W-1:0] FRESHNESS_RST = TIME_W'(2000);

  typedef enum logic [CFG_AW-1:0] {
    REG_COUNT_FALLING  = 3'd0,
    REG_DEBOUNCE_MS    = 3'd1,
    REG_RATE_WINDOW_MS = 3'd2,
    REG_PULSES_PER_REV = 3'd3,
    REG_FRESHNESS_MS   = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPD,
    S_INIT,
    S_RD,
    S_WALK,
    S_RATE,
    S_RATE_GO,
    S_RATE_WAIT,
    S_RPM,
    S_RPM_GO,
    S_RPM_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic            start;
    logic [NUMW-1:0] num;
    logic [DENW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [NUMW-1:0] quo;
  } div_rsp_t;

endpackage

@@ rtl/core/pulse_debounce_rate_rpm_meter.sv @@
// Top level: debounce, edge count, history walk and rate/RPM sequencer.
// Per input transfer the sequencer runs UPD and INIT, then RD and WALK for each of
//   W walked ring entries (at most max(edges in window + 1, MAX_INTERVALS + 1),
//   bounded by HISTORY_DEPTH), then the rate and rpm divisions on the shared
//   divider; a zero rate or rpm skips its division, and no new item is taken until
//   the result loads into the output register, which waits while an earlier result is unaccepted.
// Reset (rst_n low, synchronous): control, level state, counters and config go to
//   defaults; the edge-time memory is not cleared, the fill count masks it.
`timescale 1ns / 1ps

module pulse_debounce_rate_rpm_meter #(
  parameter int HISTORY_DEPTH = pdrm_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pdrm_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [pdrm_pkg::CFG_DW-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_raw_level,
  input  logic [pdrm_pkg::TIME_W-1:0]   in_now_ms,
  input  logic                          in_clear,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_edge_counted,
  output logic [pdrm_pkg::TIME_W-1:0]   out_hit_total,
  output logic [pdrm_pkg::OUT_W-1:0]    out_rate_x10,
  output logic [pdrm_pkg::OUT_W-1:0]    out_rpm_x10
);

  localparam int AW     = $clog2(HISTORY_DEPTH);
  localparam int CW     = $clog2(HISTORY_DEPTH + 1);
  localparam int TIME_W = pdrm_pkg::TIME_W;
  localparam int OUT_W  = pdrm_pkg::OUT_W;
  localparam int NUMW   = pdrm_pkg::NUMW;
  localparam int DENW   = pdrm_pkg::DENW;
  localparam int SUMW   = pdrm_pkg::SUMW;
  localparam int KW     = pdrm_pkg::KW;

  function automatic logic [OUT_W-1:0] sat16(input logic [NUMW-1:0] q);
    if (q > NUMW'(pdrm_pkg::SAT_MAX)) begin
      return pdrm_pkg::SAT_MAX;
    end
    return q[OUT_W-1:0];
  endfunction

  // configuration
  logic                        count_falling_r;
  logic [pdrm_pkg::DEB_W-1:0]  debounce_r;
  logic [TIME_W-1:0]           window_r;
  logic [pdrm_pkg::PPR_W-1:0]  ppr_r;
  logic [TIME_W-1:0]           fresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_falling_r <= 1'b0;
      debounce_r      <= pdrm_pkg::DEBOUNCE_RST;
      window_r        <= pdrm_pkg::WINDOW_RST;
      ppr_r           <= pdrm_pkg::PPR_RST;
      fresh_r         <= pdrm_pkg::FRESHNESS_RST;
    end else if (cfg_we) begin
      unique case (pdrm_pkg::cfg_reg_t'(cfg_addr))
        pdrm_pkg::REG_COUNT_FALLING:  count_falling_r <= cfg_wdata[0];
        pdrm_pkg::REG_DEBOUNCE_MS:    debounce_r      <= cfg_wdata[pdrm_pkg::DEB_W-1:0];
        pdrm_pkg::REG_RATE_WINDOW_MS: window_r        <= cfg_wdata[TIME_W-1:0];
        pdrm_pkg::REG_PULSES_PER_REV: ppr_r           <= cfg_wdata[pdrm_pkg::PPR_W-1:0];
        pdrm_pkg::REG_FRESHNESS_MS:   fresh_r         <= cfg_wdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  pdrm_pkg::state_t state_r, state_nxt;

  logic              raw_r, raw_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic              clr_r, clr_nxt;

  logic              started_r, started_nxt;
  logic              raw_last_r, raw_last_nxt;
  logic [TIME_W-1:0] changed_at_r, changed_at_nxt;
  logic              stable_r, stable_nxt;
  logic [TIME_W-1:0] hit_count_r, hit_count_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic              edge_r, edge_nxt;

  logic [CW-1:0]     i_r, i_nxt;
  logic [CW-1:0]     n_r, n_nxt;
  logic [CW-1:0]     avail_r, avail_nxt;
  logic              rate_on_r, rate_on_nxt;
  logic              rpm_on_r, rpm_on_nxt;
  logic              rpm_zero_r, rpm_zero_nxt;
  logic [TIME_W-1:0] prev_r, prev_nxt;
  logic [SUMW-1:0]   sum_r, sum_nxt;
  logic [KW-1:0]     k_r, k_nxt;
  logic [NUMW-1:0]   num_r, num_nxt;
  logic [DENW-1:0]   den_r, den_nxt;
  logic [OUT_W-1:0]  rate_r, rate_nxt;
  logic [OUT_W-1:0]  rpm_r, rpm_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              o_edge_r, o_edge_nxt;
  logic [TIME_W-1:0] o_hit_r, o_hit_nxt;
  logic [OUT_W-1:0]  o_rate_r, o_rate_nxt;
  logic [OUT_W-1:0]  o_rpm_r, o_rpm_nxt;

  // ring and divider hookup
  logic              wr_en;
  logic [AW-1:0]     rd_addr;
  logic [TIME_W-1:0] rd_data;
  logic [AW:0]       addr_sum;
  logic [AW:0]       addr_wrap;
  logic [TIME_W-1:0] cutoff;

  pdrm_pkg::div_req_t div_req;
  pdrm_pkg::div_rsp_t div_rsp;

  // entry i back from the newest sits at (head - 1 - i) mod depth
  assign addr_sum  = {1'b0, head_r} + (AW+1)'(HISTORY_DEPTH - 1) - (AW+1)'(i_r);
  assign addr_wrap = (addr_sum >= (AW+1)'(HISTORY_DEPTH)) ?
                     addr_sum - (AW+1)'(HISTORY_DEPTH) : addr_sum;
  assign rd_addr   = addr_wrap[AW-1:0];
  assign cutoff    = now_r - window_r;

  pdrm_ring #(
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (head_r),
    .wr_data (now_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign div_req.start = (state_r == pdrm_pkg::S_RATE_GO) ||
                         (state_r == pdrm_pkg::S_RPM_GO);
  assign div_req.num   = num_r;
  assign div_req.den   = den_r;

  pdrm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    state_nxt      = state_r;
    raw_nxt        = raw_r;
    now_nxt        = now_r;
    clr_nxt        = clr_r;
    started_nxt    = started_r;
    raw_last_nxt   = raw_last_r;
    changed_at_nxt = changed_at_r;
    stable_nxt     = stable_r;
    hit_count_nxt  = hit_count_r;
    head_nxt       = head_r;
    fill_nxt       = fill_r;
    edge_nxt       = edge_r;
    i_nxt          = i_r;
    n_nxt          = n_r;
    avail_nxt      = avail_r;
    rate_on_nxt    = rate_on_r;
    rpm_on_nxt     = rpm_on_r;
    rpm_zero_nxt   = rpm_zero_r;
    prev_nxt       = prev_r;
    sum_nxt        = sum_r;
    k_nxt          = k_r;
    num_nxt        = num_r;
    den_nxt        = den_r;
    rate_nxt       = rate_r;
    rpm_nxt        = rpm_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    o_edge_nxt     = o_edge_r;
    o_hit_nxt      = o_hit_r;
    o_rate_nxt     = o_rate_r;
    o_rpm_nxt      = o_rpm_r;
    wr_en          = 1'b0;
    in_ready       = (state_r == pdrm_pkg::S_IDLE);

    unique case (state_r)
      pdrm_pkg::S_IDLE: begin
        if (in_valid) begin
          raw_nxt   = in_raw_level;
          now_nxt   = in_now_ms;
          clr_nxt   = in_clear;
          state_nxt = pdrm_pkg::S_UPD;
        end
      end

      pdrm_pkg::S_UPD: begin
        edge_nxt = 1'b0;
        if (clr_r) begin
          hit_count_nxt = '0;
          head_nxt      = '0;
          fill_nxt      = '0;
        end else if (!started_r) begin
          started_nxt    = 1'b1;
          raw_last_nxt   = raw_r;
          stable_nxt     = raw_r;
          changed_at_nxt = now_r;
        end else if (raw_r != raw_last_r) begin
          raw_last_nxt   = raw_r;
          changed_at_nxt = now_r;
        end else if (raw_r != stable_r &&
                     (now_r - changed_at_r) >= TIME_W'(debounce_r)) begin
          stable_nxt = raw_r;
          if (raw_r == ~count_falling_r) begin
            hit_count_nxt = hit_count_r + 1'b1;
            wr_en         = 1'b1;
            head_nxt      = (head_r == AW'(HISTORY_DEPTH - 1)) ? '0 : head_r + 1'b1;
            if (fill_r < CW'(HISTORY_DEPTH)) begin
              fill_nxt = fill_r + 1'b1;
            end
            edge_nxt = 1'b1;
          end
        end
        state_nxt = pdrm_pkg::S_INIT;
      end

      pdrm_pkg::S_INIT: begin
        i_nxt        = '0;
        n_nxt        = '0;
        k_nxt        = '0;
        sum_nxt      = '0;
        rate_on_nxt  = (fill_r != '0);
        rpm_on_nxt   = (fill_r >= CW'(2)) && (ppr_r != '0);
        rpm_zero_nxt = !((fill_r >= CW'(2)) && (ppr_r != '0));
        if (32'(fill_r) > 32'(pdrm_pkg::MAX_INTERVALS + 1)) begin
          avail_nxt = CW'(pdrm_pkg::MAX_INTERVALS + 1);
        end else begin
          avail_nxt = fill_r;
        end
        state_nxt = (fill_r != '0) ? pdrm_pkg::S_RD : pdrm_pkg::S_RATE;
      end

      pdrm_pkg::S_RD: begin
        state_nxt = pdrm_pkg::S_WALK;
      end

      pdrm_pkg::S_WALK: begin
        i_nxt = i_r + 1'b1;
        if (rate_on_r) begin
          if (rd_data >= cutoff) begin
            n_nxt = n_r + 1'b1;
          end
          rate_on_nxt = (rd_data >= cutoff) && (i_nxt < fill_r);
        end
        if (rpm_on_r) begin
          if (i_r == '0) begin
            prev_nxt = rd_data;
            if ((now_r - rd_data) > fresh_r) begin
              rpm_on_nxt   = 1'b0;
              rpm_zero_nxt = 1'b1;
            end else begin
              rpm_on_nxt = (i_nxt < avail_r);
            end
          end else if (rd_data > prev_r) begin
            rpm_on_nxt = 1'b0;
          end else begin
            // equal times are skipped and keep the previous time
            if (rd_data != prev_r) begin
              sum_nxt  = sum_r + SUMW'(prev_r - rd_data);
              k_nxt    = k_r + 1'b1;
              prev_nxt = rd_data;
            end
            rpm_on_nxt = (i_nxt < avail_r);
          end
        end
        state_nxt = (!rate_on_nxt && !rpm_on_nxt) ? pdrm_pkg::S_RATE : pdrm_pkg::S_RD;
      end

      pdrm_pkg::S_RATE: begin
        if (n_r == '0) begin
          rate_nxt  = '0;
          state_nxt = pdrm_pkg::S_RPM;
        end else if (window_r == '0) begin
          rate_nxt  = pdrm_pkg::SAT_MAX;
          state_nxt = pdrm_pkg::S_RPM;
        end else begin
          num_nxt   = NUMW'(n_r) * pdrm_pkg::RATE_SCALE;
          den_nxt   = DENW'(window_r);
          state_nxt = pdrm_pkg::S_RATE_GO;
        end
      end

      pdrm_pkg::S_RATE_GO: begin
        state_nxt = pdrm_pkg::S_RATE_WAIT;
      end

      pdrm_pkg::S_RATE_WAIT: begin
        if (div_rsp.done) begin
          rate_nxt  = sat16(div_rsp.quo);
          state_nxt = pdrm_pkg::S_RPM;
        end
      end

      pdrm_pkg::S_RPM: begin
        if (rpm_zero_r || k_r == '0) begin
          rpm_nxt   = '0;
          state_nxt = pdrm_pkg::S_DONE;
        end else begin
          num_nxt   = NUMW'(k_r) * pdrm_pkg::RPM_SCALE;
          den_nxt   = DENW'(sum_r) * DENW'(ppr_r);
          state_nxt = pdrm_pkg::S_RPM_GO;
        end
      end

      pdrm_pkg::S_RPM_GO: begin
        state_nxt = pdrm_pkg::S_RPM_WAIT;
      end

      pdrm_pkg::S_RPM_WAIT: begin
        if (div_rsp.done) begin
          rpm_nxt   = sat16(div_rsp.quo);
          state_nxt = pdrm_pkg::S_DONE;
        end
      end

      pdrm_pkg::S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          o_edge_nxt    = edge_r;
          o_hit_nxt     = hit_count_r;
          o_rate_nxt    = rate_r;
          o_rpm_nxt     = rpm_r;
          state_nxt     = pdrm_pkg::S_IDLE;
        end
      end

      default: state_nxt = pdrm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pdrm_pkg::S_IDLE;
      started_r    <= 1'b0;
      raw_last_r   <= 1'b0;
      changed_at_r <= '0;
      stable_r     <= 1'b0;
      hit_count_r  <= '0;
      head_r       <= '0;
      fill_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      started_r    <= started_nxt;
      raw_last_r   <= raw_last_nxt;
      changed_at_r <= changed_at_nxt;
      stable_r     <= stable_nxt;
      hit_count_r  <= hit_count_nxt;
      head_r       <= head_nxt;
      fill_r       <= fill_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    raw_r      <= raw_nxt;
    now_r      <= now_nxt;
    clr_r      <= clr_nxt;
    edge_r     <= edge_nxt;
    i_r        <= i_nxt;
    n_r        <= n_nxt;
    avail_r    <= avail_nxt;
    rate_on_r  <= rate_on_nxt;
    rpm_on_r   <= rpm_on_nxt;
    rpm_zero_r <= rpm_zero_nxt;
    prev_r     <= prev_nxt;
    sum_r      <= sum_nxt;
    k_r        <= k_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    rate_r     <= rate_nxt;
    rpm_r      <= rpm_nxt;
    o_edge_r   <= o_edge_nxt;
    o_hit_r    <= o_hit_nxt;
    o_rate_r   <= o_rate_nxt;
    o_rpm_r    <= o_rpm_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_edge_counted = o_edge_r;
  assign out_hit_total    = o_hit_r;
  assign out_rate_x10     = o_rate_r;
  assign out_rpm_x10      = o_rpm_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(HISTORY_DEPTH))
    else $error("ring fill count above depth");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= AW'(HISTORY_DEPTH - 1))
    else $error("ring head out of range");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pdrm_pkg::S_UPD && clr_r) |=> (fill_r == '0 && hit_count_r == '0))
    else $error("clear did not empty count and ring");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == pdrm_pkg::S_RATE_WAIT || state_r == pdrm_pkg::S_RPM_WAIT))
    else $error("divider finished outside a wait state");

  a_edge_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pdrm_pkg::S_UPD && edge_nxt) |-> wr_en)
    else $error("counted edge without a ring write");

endmodule

@@ rtl/core/pdrm_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module pdrm_div (
  input  logic               clk,
  input  logic               rst_n,
  input  pdrm_pkg::div_req_t req,
  output pdrm_pkg::div_rsp_t rsp
);

  localparam int NUMW = pdrm_pkg::NUMW;
  localparam int DENW = pdrm_pkg::DENW;
  localparam int CNTW = $clog2(NUMW);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [NUMW-1:0] quo_r;
  logic [DENW-1:0] rem_r;
  logic [DENW-1:0] den_r;

  logic [DENW:0]   rem_sh;
  logic            fits;
  logic [DENW:0]   rem_sub;

  assign rem_sh  = {rem_r, quo_r[NUMW-1]};
  assign fits    = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(NUMW - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out at the top while quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.num;
      rem_r <= '0;
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= fits ? rem_sub[DENW-1:0] : rem_sh[DENW-1:0];
      quo_r <= {quo_r[NUMW-2:0], fits};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

@@ rtl/core/pdrm_ring.sv @@
// Ring of recent edge times: one write port, one registered read port.
`timescale 1ns / 1ps

module pdrm_ring #(
  parameter int DEPTH = pdrm_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  logic [pdrm_pkg::TIME_W-1:0]  wr_data,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr,
  output logic [pdrm_pkg::TIME_W-1:0]  rd_data
);

  logic [pdrm_pkg::TIME_W-1:0] mem [DEPTH];
  logic [pdrm_pkg::TIME_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ bench/tb_pulse_debounce_rate_rpm_meter.sv @@
// Self-checking testbench for the debounced tachometer edge counter.
`timescale 1ns / 1ps

module tb_pulse_debounce_rate_rpm_meter;

  localparam int TIME_W            = pdrm_pkg::TIME_W;
  localparam int OUT_W             = pdrm_pkg::OUT_W;
  localparam int CFG_AW            = pdrm_pkg::CFG_AW;
  localparam int CFG_DW            = pdrm_pkg::CFG_DW;
  localparam int DEB_W             = pdrm_pkg::DEB_W;
  localparam int PPR_W             = pdrm_pkg::PPR_W;
  localparam int HISTORY_DEPTH_DEF = pdrm_pkg::HISTORY_DEPTH_DEF;
  localparam int MAX_INTERVALS     = pdrm_pkg::MAX_INTERVALS;

  typedef struct packed {
    logic             counted;
    logic [TIME_W-1:0] hits;
    logic [OUT_W-1:0]  rate;
    logic [OUT_W-1:0]  rpm;
  } tach_res_t;

  typedef struct packed {
    logic               is_cfg;
    pdrm_pkg::cfg_reg_t reg_id;
    logic [CFG_DW-1:0]  wdata;
    logic               raw;
    logic [TIME_W-1:0]  now;
    logic               clr;
    logic               typed;
    tach_res_t          want;
  } dir_row_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;
  logic              in_valid;
  logic              in_ready;
  logic              in_raw_level;
  logic [TIME_W-1:0] in_now_ms;
  logic              in_clear;
  logic              out_valid;
  logic              out_ready;
  logic              out_edge_counted;
  logic [TIME_W-1:0] out_hit_total;
  logic [OUT_W-1:0]  out_rate_x10;
  logic [OUT_W-1:0]  out_rpm_x10;

  // predictor copy of configuration and state
  logic              cf_falling;
  logic [DEB_W-1:0]  cf_deb;
  logic [TIME_W-1:0] cf_win;
  logic [PPR_W-1:0]  cf_ppr;
  logic [TIME_W-1:0] cf_fresh;
  logic              st_started;
  logic              st_raw_last;
  logic              st_stable;
  logic [TIME_W-1:0] st_changed_at;
  logic [TIME_W-1:0] st_hits;
  logic [TIME_W-1:0] st_times [HISTORY_DEPTH_DEF];
  logic [3:0]        st_head;
  logic [4:0]        st_fill;

  tach_res_t tach_want_q [$];
  dir_row_t  dir_rows [$];
  int        tach_errors;
  int        n_samples;
  int        n_edges;
  int        n_clears;
  int        n_settings;
  bit        idle_on;

  pulse_debounce_rate_rpm_meter u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_raw_level     (in_raw_level),
    .in_now_ms        (in_now_ms),
    .in_clear         (in_clear),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_edge_counted (out_edge_counted),
    .out_hit_total    (out_hit_total),
    .out_rate_x10     (out_rate_x10),
    .out_rpm_x10      (out_rpm_x10)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", tach_want_q.size());
    $display("== FAIL ==");
    $finish;
  end

  // edge time 'back' entries behind the newest
  function automatic logic [TIME_W-1:0] time_back(int unsigned back);
    return st_times[4'(st_head - 4'd1 - 4'(back))];
  endfunction

  function automatic tach_res_t tach_predict(logic raw, logic [TIME_W-1:0] now, logic clr);
    tach_res_t         r;
    logic [TIME_W-1:0] cutoff;
    logic [TIME_W-1:0] prev;
    logic [TIME_W-1:0] t;
    longint unsigned   n;
    longint unsigned   k;
    longint unsigned   sum;
    longint unsigned   q;
    int unsigned       avail;
    r = '0;
    if (clr) begin
      st_hits = '0;
      st_head = '0;
      st_fill = '0;
    end else if (!st_started) begin
      st_started    = 1'b1;
      st_raw_last   = raw;
      st_stable     = raw;
      st_changed_at = now;
    end else if (raw != st_raw_last) begin
      st_raw_last   = raw;
      st_changed_at = now;
    end else if (raw != st_stable && (now - st_changed_at) >= TIME_W'(cf_deb)) begin
      st_stable = raw;
      if (raw != cf_falling) begin
        st_hits = st_hits + 1;
        st_times[st_head] = now;
        st_head = st_head + 4'd1;
        if (st_fill < HISTORY_DEPTH_DEF) st_fill = st_fill + 5'd1;
        r.counted = 1'b1;
      end
    end
    r.hits = st_hits;

    // count edges inside the window, newest first
    cutoff = now - cf_win;
    n = 0;
    for (int i = 0; i < st_fill; i++) begin
      if (time_back(i) >= cutoff) n++;
      else break;
    end
    if (n == 0) r.rate = '0;
    else if (cf_win == 0) r.rate = pdrm_pkg::SAT_MAX;
    else begin
      q = (64'd10000 * n) / 64'(cf_win);
      r.rate = (q > 64'd65535) ? pdrm_pkg::SAT_MAX : OUT_W'(q);
    end

    r.rpm = '0;
    if (st_fill >= 2 && cf_ppr != 0 && (now - time_back(0)) <= cf_fresh) begin
      prev  = time_back(0);
      sum   = 0;
      k     = 0;
      avail = (st_fill > MAX_INTERVALS + 1) ? MAX_INTERVALS + 1 : st_fill;
      for (int i = 1; i < avail; i++) begin
        t = time_back(i);
        if (t > prev) break;
        if (t == prev) continue;
        sum += 64'(prev - t);
        k++;
        prev = t;
      end
      if (k != 0) begin
        q = (64'd600000 * k) / (sum * 64'(cf_ppr));
        r.rpm = (q > 64'd65535) ? pdrm_pkg::SAT_MAX : OUT_W'(q);
      end
    end
    return r;
  endfunction

  function automatic dir_row_t row_smp(logic raw, logic [TIME_W-1:0] now, logic clr);
    dir_row_t d;
    d     = '0;
    d.raw = raw;
    d.now = now;
    d.clr = clr;
    return d;
  endfunction

  function automatic dir_row_t row_chk(logic raw, logic [TIME_W-1:0] now, logic clr,
                                       logic c, logic [TIME_W-1:0] h,
                                       logic [OUT_W-1:0] rate, logic [OUT_W-1:0] rpm);
    dir_row_t d;
    d       = row_smp(raw, now, clr);
    d.typed = 1'b1;
    d.want  = '{c, h, rate, rpm};
    return d;
  endfunction

  function automatic dir_row_t row_cfg(pdrm_pkg::cfg_reg_t id, logic [CFG_DW-1:0] v);
    dir_row_t d;
    d        = '0;
    d.is_cfg = 1'b1;
    d.reg_id = id;
    d.wdata  = v;
    return d;
  endfunction

  task automatic push_sample(logic raw, logic [TIME_W-1:0] now, logic clr,
                             logic typed, tach_res_t want);
    tach_res_t pred;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 9)) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_raw_level <= raw;
    in_now_ms    <= now;
    in_clear     <= clr;
    do @(posedge clk); while (!in_ready);
    pred = tach_predict(raw, now, clr);
    n_samples++;
    n_edges  += pred.counted;
    n_clears += clr;
    tach_want_q.push_back(typed ? want : pred);
  endtask

  // drop valid and wait until the block has delivered everything
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tach_want_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(pdrm_pkg::cfg_reg_t id, logic [CFG_DW-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= id;
    cfg_wdata <= v;
    @(posedge clk);
    case (id)
      pdrm_pkg::REG_COUNT_FALLING:  cf_falling = v[0];
      pdrm_pkg::REG_DEBOUNCE_MS:    cf_deb     = v[DEB_W-1:0];
      pdrm_pkg::REG_RATE_WINDOW_MS: cf_win     = v;
      pdrm_pkg::REG_PULSES_PER_REV: cf_ppr     = v[PPR_W-1:0];
      pdrm_pkg::REG_FRESHNESS_MS:   cf_fresh   = v;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [CFG_DW-1:0] falling, logic [CFG_DW-1:0] deb,
                            logic [CFG_DW-1:0] win, logic [CFG_DW-1:0] ppr,
                            logic [CFG_DW-1:0] fresh);
    drain_results();
    cfg_write(pdrm_pkg::REG_COUNT_FALLING, falling);
    cfg_write(pdrm_pkg::REG_DEBOUNCE_MS, deb);
    cfg_write(pdrm_pkg::REG_RATE_WINDOW_MS, win);
    cfg_write(pdrm_pkg::REG_PULSES_PER_REV, ppr);
    cfg_write(pdrm_pkg::REG_FRESHNESS_MS, fresh);
    n_settings++;
  endtask

  // receiver with stall bursts
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    tach_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (tach_want_q.size() == 0) begin
        $display("%0t: result transfer with nothing pending", $time);
        tach_errors++;
      end else begin
        want = tach_want_q.pop_front();
        if (out_edge_counted !== want.counted) begin
          $display("%0t: edge_counted expected %0d actual %0d",
                   $time, want.counted, out_edge_counted);
          tach_errors++;
        end
        if (out_hit_total !== want.hits) begin
          $display("%0t: hit_total expected %0d actual %0d", $time, want.hits, out_hit_total);
          tach_errors++;
        end
        if (out_rate_x10 !== want.rate) begin
          $display("%0t: rate_x10 expected %0d actual %0d", $time, want.rate, out_rate_x10);
          tach_errors++;
        end
        if (out_rpm_x10 !== want.rpm) begin
          $display("%0t: rpm_x10 expected %0d actual %0d", $time, want.rpm, out_rpm_x10);
          tach_errors++;
        end
      end
    end
  end

  initial begin
    dir_row_t          row;
    logic              lvl;
    logic              raw;
    logic              clr;
    logic [TIME_W-1:0] cur_t;
    logic [TIME_W-1:0] now;
    int                hold;
    int                kind;
    int unsigned       stp;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_raw_level = 1'b0;
    in_now_ms    = '0;
    in_clear     = 1'b0;
    idle_on      = 1'b1;
    tach_errors  = 0;
    n_samples    = 0;
    n_edges      = 0;
    n_clears     = 0;
    n_settings   = 1;

    cf_falling    = 1'b0;
    cf_deb        = pdrm_pkg::DEBOUNCE_RST;
    cf_win        = pdrm_pkg::WINDOW_RST;
    cf_ppr        = pdrm_pkg::PPR_RST;
    cf_fresh      = pdrm_pkg::FRESHNESS_RST;
    st_started    = 1'b0;
    st_raw_last   = 1'b0;
    st_stable     = 1'b0;
    st_changed_at = '0;
    st_hits       = '0;
    st_head       = '0;
    st_fill       = '0;
    foreach (st_times[j]) st_times[j] = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // first sample, debounce boundary, rising count, stale rpm, clear
    dir_rows.push_back(row_chk(1'b0, 32'd10000, 1'b0, 1'b0, 32'd0, 16'd0, 16'd0));
    dir_rows.push_back(row_chk(1'b1, 32'd10001, 1'b0, 1'b0, 32'd0, 16'd0, 16'd0));
    dir_rows.push_back(row_chk(1'b1, 32'd10005, 1'b0, 1'b0, 32'd0, 16'd0, 16'd0));
    dir_rows.push_back(row_chk(1'b1, 32'd10006, 1'b0, 1'b1, 32'd1, 16'd10, 16'd0));
    dir_rows.push_back(row_chk(1'b0, 32'd10010, 1'b0, 1'b0, 32'd1, 16'd10, 16'd0));
    dir_rows.push_back(row_chk(1'b0, 32'd10015, 1'b0, 1'b0, 32'd1, 16'd10, 16'd0));
    dir_rows.push_back(row_chk(1'b1, 32'd10020, 1'b0, 1'b0, 32'd1, 16'd10, 16'd0));
    dir_rows.push_back(row_chk(1'b1, 32'd10026, 1'b0, 1'b1, 32'd2, 16'd20, 16'd30000));
    dir_rows.push_back(row_chk(1'b1, 32'd12026, 1'b0, 1'b0, 32'd2, 16'd0, 16'd30000));
    dir_rows.push_back(row_chk(1'b1, 32'd12027, 1'b0, 1'b0, 32'd2, 16'd0, 16'd0));
    dir_rows.push_back(row_chk(1'b0, 32'd12028, 1'b1, 1'b0, 32'd0, 16'd0, 16'd0));
    // no debounce, 1 ms window: unsaturated rate, saturated rpm, equal edge times
    dir_rows.push_back(row_cfg(pdrm_pkg::REG_DEBOUNCE_MS, 32'd0));
    dir_rows.push_back(row_cfg(pdrm_pkg::REG_RATE_WINDOW_MS, 32'd1));
    for (int j = 0; j < 3; j++) begin
      dir_rows.push_back(row_smp(1'b0, 32'd20000 + ((j == 0) ? 0 : 1), 1'b0));
      dir_rows.push_back(row_smp(1'b0, 32'd20000 + ((j == 0) ? 0 : 1), 1'b0));
      dir_rows.push_back(row_smp(1'b1, 32'd20000 + ((j == 0) ? 0 : 1), 1'b0));
      dir_rows.push_back(row_smp(1'b1, 32'd20000 + ((j == 0) ? 0 : 1), 1'b0));
    end
    // falling count, zero window, zero pulses per rev, time extremes
    dir_rows.push_back(row_cfg(pdrm_pkg::REG_COUNT_FALLING, 32'd1));
    dir_rows.push_back(row_cfg(pdrm_pkg::REG_RATE_WINDOW_MS, 32'd0));
    dir_rows.push_back(row_cfg(pdrm_pkg::REG_PULSES_PER_REV, 32'd0));
    dir_rows.push_back(row_smp(1'b0, 32'hFFFF_FFFF, 1'b0));
    dir_rows.push_back(row_smp(1'b0, 32'hFFFF_FFFF, 1'b0));
    dir_rows.push_back(row_smp(1'b1, 32'd0, 1'b0));
    dir_rows.push_back(row_smp(1'b1, 32'd0, 1'b0));

    foreach (dir_rows[j]) begin
      row = dir_rows[j];
      if (row.is_cfg) begin
        drain_results();
        cfg_write(row.reg_id, row.wdata);
      end else begin
        push_sample(row.raw, row.now, row.clr, row.typed, row.want);
      end
    end

    lvl  = 1'b0;
    hold = 0;
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: set_config(32'd0, 32'd5, 32'd1000, 32'd1, 32'd2000);
        1: set_config(32'd1, 32'd0, 32'd1, 32'd1, 32'd0);
        2: set_config(32'd0, 32'd65535, 32'hFFFF_FFFF, 32'd65535, 32'hFFFF_FFFF);
        3: set_config(32'd1, 32'd2, 32'd0, 32'd0, 32'd50);
        4: set_config(32'd0, 32'd3, 32'd20, 32'd2, 32'd100);
        8: set_config(32'd1, 32'd4, 32'd300, 32'd3, 32'd400);
        default: begin
          // upper bits of the narrow registers carry random junk
          set_config($urandom, ($urandom_range(0, 1) ? $urandom_range(0, 20) : $urandom),
                     ($urandom_range(0, 1) ? $urandom_range(1, 300) : $urandom),
                     ($urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom),
                     ($urandom_range(0, 1) ? $urandom_range(0, 500) : $urandom));
        end
      endcase
      idle_on = (ph != 4 && ph != 8);
      cur_t   = (ph % 3 == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 5000) : $urandom;

      for (int j = 0; j < 195; j++) begin
        kind = $urandom_range(0, 99);
        clr  = 1'b0;
        if (kind < 2) begin
          raw = $urandom_range(0, 1);
          clr = 1'b1;
          now = cur_t;
        end else if (kind < 6) begin
          raw = $urandom_range(0, 1);
          now = $urandom;
        end else if (kind < 12) begin
          // short glitch that should not survive a nonzero debounce
          raw = ~lvl;
          now = cur_t + ((cf_deb == 0) ? 0 : $urandom_range(0, cf_deb - 1));
        end else begin
          if (hold == 0) begin
            lvl  = ~lvl;
            hold = $urandom_range(1, 4);
            stp  = $urandom_range(0, 3);
          end else begin
            hold--;
            if ($urandom_range(0, 7) == 0) stp = $urandom_range(0, 2 * cf_deb + 50);
            else stp = $urandom_range(0, cf_deb / 2 + 2);
          end
          if ($urandom_range(0, 32) == 0) stp += $urandom_range(0, 4000);
          cur_t = cur_t + stp;
          raw   = lvl;
          now   = cur_t;
        end
        push_sample(raw, now, clr, 1'b0, '0);
      end
    end

    drain_results();
    repeat (100) @(posedge clk);

    $display("Covered %0d samples with %0d counted edges and %0d clears", n_samples, n_edges,
             n_clears);
    $display("across %0d register settings, including window, debounce and time extremes",
             n_settings);
    if (tach_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", tach_errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/pdrm_pkg.sv
rtl/core/pdrm_div.sv
rtl/core/pdrm_ring.sv
rtl/core/pulse_debounce_rate_rpm_meter.sv
bench/tb_pulse_debounce_rate_rpm_meter.sv
